// ----- rtl/core/assert_macros.svh -----
// assertion macros for the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked at every clock outside reset
`define PRMV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define PRMV_ASSERT_IMPLY(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define PRMV_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

// ----- rtl/core/prmv_pkg.sv -----
// package: widths, defaults and register map of the running mean / variance block
package prmv_pkg;

  localparam int MAX_PIXELS_DFLT = 65536;
  localparam int COUNT_BITS_DFLT = 16;

  localparam int FP_W = 17;
  localparam logic [FP_W-1:0] FP_RESET = 17'h10000;

  localparam int PIX_W  = 8;
  localparam int FRAC_W = 16;
  localparam int MEAN_W = 24;
  localparam int SUM_W  = 48;
  localparam int VAR_W  = 30;
  localparam int IDX_W  = 16;

  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_SEL_W = PADDR_W - 2;
  localparam logic [REG_SEL_W-1:0] REG_FRAME_PIXELS = '0;

  // stages from issue to deviation sum write back
  localparam int RMW_DEPTH = MEAN_W + 2;

  localparam logic [SUM_W:0] TERM_ROUND = (SUM_W + 1)'(1) << (FRAC_W - 1);

endpackage

// ----- rtl/core/pixel_running_mean_variance.sv -----
// top level: per-pixel running mean and variance over video frames
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------------
//  in       | in_valid_i / in_stall_o    | pixel_value_i
//  out      | out_valid_o / out_stall_i  | pixel_index_o frames_seen_o mean_value_o
//           |                            | variance_value_o
//  config   | psel penable pwrite pready | paddr pwdata prdata
//
// one item per cycle while the input is not stalled; acceptance to the output register
//   runs through the 24-step mean divider and the 30-step variance divider
// after reset a clearing pass writes zero to every entry of both stores,
//   during which no item is accepted
// an entry's read-modify-write spans RMW_DEPTH (26) stages, so with a frame
//   of 26 pixels or fewer input stalls until the earlier update of the same
//   pixel has been written back
// one skid register behind the output register; the whole pipeline holds
//   only while the skid register is full
`include "assert_macros.svh"

module pixel_running_mean_variance #(
  parameter int MAX_PIXELS = prmv_pkg::MAX_PIXELS_DFLT,
  parameter int COUNT_BITS = prmv_pkg::COUNT_BITS_DFLT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [prmv_pkg::PADDR_W-1:0]  paddr,
  input  logic [prmv_pkg::PDATA_W-1:0]  pwdata,
  output logic [prmv_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  // pixel items
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [prmv_pkg::PIX_W-1:0]    pixel_value_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [prmv_pkg::IDX_W-1:0]    pixel_index_o,
  output logic [prmv_pkg::IDX_W-1:0]    frames_seen_o,
  output logic [prmv_pkg::MEAN_W-1:0]   mean_value_o,
  output logic [prmv_pkg::VAR_W-1:0]    variance_value_o
);
  import prmv_pkg::*;

  localparam int AW   = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int LW   = $clog2(MAX_PIXELS + 1);
  localparam int XW   = (LW > FP_W) ? LW : FP_W;
  localparam int CB   = COUNT_BITS;
  localparam int FCX  = (CB > IDX_W) ? CB : IDX_W;
  localparam int PXW  = (AW > IDX_W) ? AW : IDX_W;
  localparam int DWA  = ((MEAN_W > CB - 1) ? MEAN_W : CB - 1) + 1;
  localparam int DWB  = SUM_W + 1;
  localparam int SATW = (DWB > CB + VAR_W) ? DWB : CB + VAR_W;
  localparam int IW   = $clog2(RMW_DEPTH + 1);

  // item state between stages
  typedef struct packed {
    logic [AW-1:0]    pos;
    logic [IDX_W-1:0] fs;
    logic [PIX_W-1:0] x;
    logic [CB-1:0]    n;
  } s1_t;

  typedef struct packed {
    logic [AW-1:0]     pos;
    logic [IDX_W-1:0]  fs;
    logic [PIX_W-1:0]  x;
    logic [CB-1:0]     n;
    logic              up;
    logic [MEAN_W-1:0] adelta;
  } sa_t;

  typedef struct packed {
    logic [AW-1:0]     pos;
    logic [IDX_W-1:0]  fs;
    logic [CB-1:0]     n;
    logic [MEAN_W-1:0] mean;
    logic [SUM_W-1:0]  prod;
  } s2_t;

  typedef struct packed {
    logic [AW-1:0]     pos;
    logic [IDX_W-1:0]  fs;
    logic [CB-1:0]     n;
    logic [MEAN_W-1:0] mean;
    logic [SUM_W-1:0]  sum;
  } s3_t;

  typedef struct packed {
    logic [AW-1:0]     pos;
    logic [IDX_W-1:0]  fs;
    logic [CB-1:0]     n;
    logic [MEAN_W-1:0] mean;
    logic [DWB-1:0]    dvd;
  } s4_t;

  typedef struct packed {
    logic [AW-1:0]     pos;
    logic [IDX_W-1:0]  fs;
    logic [MEAN_W-1:0] mean;
    logic              sat;
  } sb_t;

  typedef struct packed {
    logic [IDX_W-1:0]  pix;
    logic [IDX_W-1:0]  fs;
    logic [MEAN_W-1:0] mean;
    logic [VAR_W-1:0]  var_v;
  } out_t;

  // ---------------------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------------------
  logic [FP_W-1:0] frame_pixels_q;
  logic            cfg_we;
  logic            reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:2] == REG_FRAME_PIXELS);
  assign cfg_we  = psel & penable & pwrite & pready;
  assign prdata  = reg_hit ? PDATA_W'(frame_pixels_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_pixels_q <= FP_RESET;
    end else if (cfg_we && reg_hit) begin
      frame_pixels_q <= pwdata[FP_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // clearing pass over both stores after reset
  // ---------------------------------------------------------------------------
  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == AW'(MAX_PIXELS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // issue: raster position, frame count, hazard check
  // ---------------------------------------------------------------------------
  logic [AW-1:0]    pos_q;
  logic [CB-1:0]    fc_q;
  logic [IW-1:0]    inflight_q;
  logic             skid_vld_q;
  logic             en;
  logic             in_acc;
  logic             hazard;
  logic [XW-1:0]    fp_x;
  logic [XW-1:0]    len_x;
  logic [XW-1:0]    pos_cur_x;
  logic [XW-1:0]    pos_inc_x;
  logic [AW-1:0]    pos_cur;
  logic [AW-1:0]    pos_nxt;
  logic [CB-1:0]    fc_new;
  logic [CB-1:0]    n_new;
  logic [FCX-1:0]   fc_x;
  logic [IDX_W-1:0] fs_new;

  // the whole pipeline moves unless the skid register is occupied
  assign en = ~skid_vld_q;

  // frame length zero acts as one, beyond the store acts as the store size
  assign fp_x  = XW'(frame_pixels_q);
  assign len_x = (fp_x == '0) ? XW'(1)
               : ((fp_x > XW'(MAX_PIXELS)) ? XW'(MAX_PIXELS) : fp_x);

  // position left past a shortened frame restarts at zero
  assign pos_cur_x = (XW'(pos_q) >= len_x) ? '0 : XW'(pos_q);
  assign pos_cur   = AW'(pos_cur_x);
  assign pos_inc_x = pos_cur_x + XW'(1);
  assign pos_nxt   = (pos_inc_x >= len_x) ? '0 : AW'(pos_inc_x);

  // frame count rises on the first pixel of a frame and saturates
  assign fc_new = ((pos_cur_x == '0) && (fc_q != '1)) ? fc_q + 1'b1 : fc_q;
  assign n_new  = (fc_new == '0) ? CB'(1) : fc_new;
  assign fc_x   = FCX'(fc_new);
  assign fs_new = (fc_x > FCX'(16'hFFFF)) ? '1 : fc_x[IDX_W-1:0];

  // in-flight items occupy consecutive positions, so a collision exists
  // exactly when at least a frame's worth of them are pending
  assign hazard     = (XW'(inflight_q) >= len_x);
  assign in_stall_o = clr_busy_q | skid_vld_q | hazard;
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      fc_q  <= '0;
    end else if (in_acc) begin
      pos_q <= pos_nxt;
      fc_q  <= fc_new;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: issued item with the old mean from the store
  // ---------------------------------------------------------------------------
  logic              s1_vld_q;
  s1_t               s1_q;
  logic [MEAN_W-1:0] mean_rd;
  logic              mean_we;
  logic [AW-1:0]     mean_waddr;
  logic [MEAN_W-1:0] mean_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q.pos <= pos_cur;
      s1_q.fs  <= fs_new;
      s1_q.x   <= pixel_value_i;
      s1_q.n   <= n_new;
    end
  end

  prmv_ram #(
    .DEPTH (MAX_PIXELS),
    .WIDTH (MEAN_W),
    .AW    (AW)
  ) u_mean_ram (
    .clk_i   (clk_i),
    .we_i    (mean_we),
    .waddr_i (mean_waddr),
    .wdata_i (mean_wdata),
    .re_i    (en),
    .raddr_i (pos_cur),
    .rdata_o (mean_rd)
  );

  // delta magnitude and direction; mean step rounds half away from zero
  logic [MEAN_W-1:0] x1;
  logic              up1;
  logic [MEAN_W-1:0] adelta1;
  logic [DWA-1:0]    dvd_a;
  sa_t               sa_d;

  assign x1      = {s1_q.x, FRAC_W'(0)};
  assign up1     = (x1 >= mean_rd);
  assign adelta1 = up1 ? x1 - mean_rd : mean_rd - x1;
  assign dvd_a   = DWA'(adelta1) + DWA'(s1_q.n >> 1);

  always_comb begin
    sa_d.pos    = s1_q.pos;
    sa_d.fs     = s1_q.fs;
    sa_d.x      = s1_q.x;
    sa_d.n      = s1_q.n;
    sa_d.up     = up1;
    sa_d.adelta = adelta1;
  end

  // ---------------------------------------------------------------------------
  // mean step divider
  // ---------------------------------------------------------------------------
  logic              a_vld;
  logic [MEAN_W-1:0] a_quo;
  sa_t               sa_q;

  prmv_divider #(
    .DW (DWA),
    .NW (CB),
    .QW (MEAN_W),
    .SW ($bits(sa_t))
  ) u_div_mean (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (s1_vld_q),
    .dividend_i (dvd_a),
    .divisor_i  (s1_q.n),
    .side_i     (sa_d),
    .valid_o    (a_vld),
    .quotient_o (a_quo),
    .side_o     (sa_q)
  );

  // new mean lies between old mean and x: distance to x is adelta - step
  logic [MEAN_W-1:0] xa;
  logic [MEAN_W-1:0] ad2;
  logic [MEAN_W-1:0] m_new;
  logic [SUM_W-1:0]  prod_a;

  assign xa     = {sa_q.x, FRAC_W'(0)};
  assign ad2    = sa_q.adelta - a_quo;
  assign m_new  = sa_q.up ? xa - ad2 : xa + ad2;
  assign prod_a = sa_q.adelta * ad2;

  assign mean_we    = clr_busy_q | (en & a_vld);
  assign mean_waddr = clr_busy_q ? clr_addr_q : sa_q.pos;
  assign mean_wdata = clr_busy_q ? '0 : m_new;

  // ---------------------------------------------------------------------------
  // stage 2: registered product, old deviation sum from the store
  // ---------------------------------------------------------------------------
  logic             s2_vld_q;
  s2_t              s2_q;
  logic [SUM_W-1:0] sum_rd;
  logic             sum_we;
  logic [AW-1:0]    sum_waddr;
  logic [SUM_W-1:0] sum_wdata;
  logic             sum_wb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= a_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q.pos  <= sa_q.pos;
      s2_q.fs   <= sa_q.fs;
      s2_q.n    <= sa_q.n;
      s2_q.mean <= m_new;
      s2_q.prod <= prod_a;
    end
  end

  prmv_ram #(
    .DEPTH (MAX_PIXELS),
    .WIDTH (SUM_W),
    .AW    (AW)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata),
    .re_i    (en),
    .raddr_i (sa_q.pos),
    .rdata_o (sum_rd)
  );

  // deviation term rounded to Q32.16, sum saturates at its width
  logic [SUM_W:0]        term_x;
  logic [SUM_W:0]        sum_x;
  logic [SUM_W-1:0]      sum_new;

  assign term_x  = {1'b0, s2_q.prod} + TERM_ROUND;
  assign sum_x   = {1'b0, sum_rd} + ((SUM_W + 1)'(term_x[SUM_W:FRAC_W]));
  assign sum_new = sum_x[SUM_W] ? '1 : sum_x[SUM_W-1:0];

  // write back ends the read-modify-write window of this item
  assign sum_wb    = en & s2_vld_q;
  assign sum_we    = clr_busy_q | sum_wb;
  assign sum_waddr = clr_busy_q ? clr_addr_q : s2_q.pos;
  assign sum_wdata = clr_busy_q ? '0 : sum_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (in_acc && !sum_wb) begin
      inflight_q <= inflight_q + 1'b1;
    end else if (!in_acc && sum_wb) begin
      inflight_q <= inflight_q - 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3 and 4: rounded variance dividend, saturation check
  // ---------------------------------------------------------------------------
  logic s3_vld_q;
  s3_t  s3_q;
  logic s4_vld_q;
  s4_t  s4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else if (en) begin
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q.pos  <= s2_q.pos;
      s3_q.fs   <= s2_q.fs;
      s3_q.n    <= s2_q.n;
      s3_q.mean <= s2_q.mean;
      s3_q.sum  <= sum_new;
      s4_q.pos  <= s3_q.pos;
      s4_q.fs   <= s3_q.fs;
      s4_q.n    <= s3_q.n;
      s4_q.mean <= s3_q.mean;
      s4_q.dvd  <= DWB'(s3_q.sum) + DWB'(s3_q.n >> 1);
    end
  end

  // a quotient of 2^30 or more saturates; the divider then sees zero
  logic           var_sat;
  logic [DWB-1:0] dvd_b;
  sb_t            sb_d;

  assign var_sat = (SATW'(s4_q.dvd) >= (SATW'(s4_q.n) << VAR_W));
  assign dvd_b   = var_sat ? '0 : s4_q.dvd;

  always_comb begin
    sb_d.pos  = s4_q.pos;
    sb_d.fs   = s4_q.fs;
    sb_d.mean = s4_q.mean;
    sb_d.sat  = var_sat;
  end

  // ---------------------------------------------------------------------------
  // variance divider
  // ---------------------------------------------------------------------------
  logic             b_vld;
  logic [VAR_W-1:0] b_quo;
  sb_t              sb_q;

  prmv_divider #(
    .DW (DWB),
    .NW (CB),
    .QW (VAR_W),
    .SW ($bits(sb_t))
  ) u_div_var (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (s4_vld_q),
    .dividend_i (dvd_b),
    .divisor_i  (s4_q.n),
    .side_i     (sb_d),
    .valid_o    (b_vld),
    .quotient_o (b_quo),
    .side_o     (sb_q)
  );

  // ---------------------------------------------------------------------------
  // output register and skid register
  // ---------------------------------------------------------------------------
  out_t           res_d;
  logic [PXW-1:0] pix_x;
  logic           out_vld_q;
  out_t           out_q;
  out_t           skid_q;
  logic           take_out;

  assign pix_x = PXW'(sb_q.pos);

  always_comb begin
    res_d.pix   = pix_x[IDX_W-1:0];
    res_d.fs    = sb_q.fs;
    res_d.mean  = sb_q.mean;
    res_d.var_v = sb_q.sat ? '1 : b_quo;
  end

  assign take_out = out_vld_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (take_out) begin
        skid_vld_q <= 1'b0;
      end
    end else if (b_vld) begin
      if (!out_vld_q || take_out) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (take_out) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (take_out) begin
        out_q <= skid_q;
      end
    end else if (b_vld) begin
      if (!out_vld_q || take_out) begin
        out_q <= res_d;
      end else begin
        skid_q <= res_d;
      end
    end
  end

  assign out_valid_o      = out_vld_q;
  assign pixel_index_o    = out_q.pix;
  assign frames_seen_o    = out_q.fs;
  assign mean_value_o     = out_q.mean;
  assign variance_value_o = out_q.var_v;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `PRMV_ASSERT(a_inflight_bound, inflight_q <= IW'(RMW_DEPTH), "in-flight count beyond window")
  `PRMV_ASSERT_IMPLY(a_no_issue_clr, clr_busy_q, !in_acc, "item accepted during clearing")
  `PRMV_ASSERT_IMPLY(a_skid_needs_out, skid_vld_q, out_vld_q, "skid full with empty output")
  `PRMV_ASSERT_IMPLY(a_wb_counted, sum_wb, inflight_q != '0, "write back with nothing in flight")
  `PRMV_ASSERT_NEXT(a_skid_freeze, skid_vld_q && out_stall_i, skid_vld_q, "skid dropped while stalled")

endmodule

// ----- rtl/core/prmv_ram.sv -----
// single write port, single registered read port memory
module prmv_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8,
  parameter int AW    = 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/prmv_divider.sv -----
// pipelined restoring divider, one quotient bit per stage, with sideband
module prmv_divider #(
  parameter int DW = 25,
  parameter int NW = 16,
  parameter int QW = 24,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [NW-1:0] divisor_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quotient_o,
  output logic [SW-1:0] side_o
);

  // dividend must stay below divisor << QW
  localparam int CW = (DW > NW + QW) ? DW : NW + QW;

  logic [QW-1:0] vld_q;
  logic [CW-1:0] rem_q  [QW];
  logic [QW-1:0] quo_q  [QW];
  logic [NW-1:0] dvs_q  [QW];
  logic [SW-1:0] side_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic          vld_in;
    logic [CW-1:0] rem_in;
    logic [QW-1:0] quo_in;
    logic [NW-1:0] dvs_in;
    logic [SW-1:0] side_in;
    logic [CW-1:0] trial;
    logic          take;

    if (s == 0) begin : g_head
      assign vld_in  = valid_i;
      assign rem_in  = CW'(dividend_i);
      assign quo_in  = '0;
      assign dvs_in  = divisor_i;
      assign side_in = side_i;
    end else begin : g_body
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign dvs_in  = dvs_q[s-1];
      assign side_in = side_q[s-1];
    end

    assign trial = CW'(dvs_in) << (QW - 1 - s);
    assign take  = (rem_in >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= take ? rem_in - trial : rem_in;
        quo_q[s]  <= quo_in | (QW'(take) << (QW - 1 - s));
        dvs_q[s]  <= dvs_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o    = vld_q[QW-1];
  assign quotient_o = quo_q[QW-1];
  assign side_o     = side_q[QW-1];

endmodule

// ----- bench/tb_pixel_running_mean_variance.sv -----
// testbench for pixel_running_mean_variance: directed and random pixels checked against a predictor
`timescale 1ns / 100ps

module tb_pixel_running_mean_variance;
  import prmv_pkg::*;

  localparam int NPIX        = MAX_PIXELS_DFLT;
  localparam int COUNT_MAX   = (1 << COUNT_BITS_DFLT) - 1;
  localparam int DRAIN_WAIT  = 70;         // margin for the pipeline to drain
  localparam int CYCLE_LIMIT = 1_500_000;  // clearing pass + slowest run, several times over
  localparam int LONG_HOLD   = 400;
  localparam int RAND_ITEMS  = 250;        // per register setting

  // register addresses; the second lies past the register map and must be ignored
  localparam logic [PADDR_W-1:0] ADDR_FRAME_PIXELS = {REG_FRAME_PIXELS, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_UNMAPPED     = 3'd4;

  typedef struct {
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  frames;
    logic [MEAN_W-1:0] mean;
    logic [VAR_W-1:0]  variance;
  } pixel_stats_t;

  typedef enum logic [1:0] {ROW_PIXEL, ROW_CHECKED, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic [PADDR_W-1:0] addr;
    int unsigned       value;   // pixel or register data
    pixel_stats_t      stats;   // typed expectation for checked rows
  } dir_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [PIX_W-1:0]   pixel_value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [IDX_W-1:0]   pixel_index_o;
  logic [IDX_W-1:0]   frames_seen_o;
  logic [MEAN_W-1:0]  mean_value_o;
  logic [VAR_W-1:0]   variance_value_o;

  pixel_running_mean_variance u_top (.*);

  always #5 clk_i = ~clk_i;

  // predictor state, a private copy of the block's stores and counters
  logic [MEAN_W-1:0] mean_mem [NPIX];
  logic [SUM_W-1:0]  devsum_mem [NPIX];
  int unsigned       raster_pos;
  int unsigned       frame_cnt;
  logic [FP_W-1:0]   frame_len_reg;

  pixel_stats_t pending_stats_q[$];
  int unsigned  error_cnt = 0;
  int unsigned  cycle_cnt = 0;
  bit           long_hold_req = 1'b0;

  // welford update of one pixel; returns the expected result item
  function automatic pixel_stats_t welford_update(input logic [PIX_W-1:0] pix);
    int unsigned       len;
    int unsigned       pos;
    longint unsigned   n, x, m_old, m_new, adelta, stp, ad2, term, sum, v;
    pixel_stats_t      r;
    len = frame_len_reg;
    if (len == 0) len = 1;
    if (len > NPIX) len = NPIX;
    // a lowered frame length can leave the position past the end: new frame
    if (raster_pos >= len) raster_pos = 0;
    pos = raster_pos;
    if (pos == 0 && frame_cnt < COUNT_MAX) frame_cnt++;
    n = (frame_cnt == 0) ? 1 : frame_cnt;
    x = longint'(pix) << FRAC_W;
    m_old = mean_mem[pos];
    // mean step rounds half away from zero and never overshoots x
    adelta = (x >= m_old) ? x - m_old : m_old - x;
    stp = (adelta + n / 2) / n;
    if (stp > adelta) stp = adelta;
    m_new = (x >= m_old) ? m_old + stp : m_old - stp;
    ad2 = (x >= m_new) ? x - m_new : m_new - x;
    term = (adelta * ad2 + 64'h8000) >> FRAC_W;
    sum = devsum_mem[pos];
    if (sum > (64'h0000_FFFF_FFFF_FFFF - term)) sum = 64'h0000_FFFF_FFFF_FFFF;
    else sum = sum + term;
    mean_mem[pos] = m_new[MEAN_W-1:0];
    devsum_mem[pos] = sum[SUM_W-1:0];
    v = (sum + n / 2) / n;
    if (v > 64'h3FFF_FFFF) v = 64'h3FFF_FFFF;
    r.idx = pos[IDX_W-1:0];
    r.frames = frame_cnt[IDX_W-1:0];
    r.mean = m_new[MEAN_W-1:0];
    r.variance = v[VAR_W-1:0];
    raster_pos = pos + 1;
    if (raster_pos >= len) raster_pos = 0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_cnt);
    error_cnt++;
  endtask

  // result checker, sampled at the rising edge
  always @(posedge clk_i) begin
    pixel_stats_t w;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_stats_q.size() == 0) begin
        report_mismatch("unexpected item, index", pixel_index_o, 0);
      end else begin
        w = pending_stats_q.pop_front();
        if (pixel_index_o !== w.idx) report_mismatch("pixel_index", pixel_index_o, w.idx);
        if (frames_seen_o !== w.frames) report_mismatch("frames_seen", frames_seen_o, w.frames);
        if (mean_value_o !== w.mean) report_mismatch("mean_value", mean_value_o, w.mean);
        if (variance_value_o !== w.variance)
          report_mismatch("variance_value", variance_value_o, w.variance);
      end
    end
  end

  // receiver stall: random stretches of free flow and of random stalling,
  // plus one long hold-off on request so the pipeline backs up into the input
  initial begin
    int seg;
    bit choppy;
    forever begin
      if (long_hold_req) begin
        @(negedge clk_i) out_stall_i <= 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
        long_hold_req = 1'b0;
      end else begin
        seg = $urandom_range(5, 60);
        choppy = $urandom_range(0, 2) != 0;
        repeat (seg) begin
          @(negedge clk_i);
          out_stall_i <= choppy ? ($urandom_range(0, 2) == 0) : 1'b0;
          if (long_hold_req) break;
        end
      end
    end
  end

  // one config write, setup then access phase; called at a falling edge
  task automatic apb_write(input logic [PADDR_W-1:0] addr, input int unsigned data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(negedge clk_i) penable <= 1'b1;
    @(posedge clk_i);
    if (addr == ADDR_FRAME_PIXELS) frame_len_reg = data[FP_W-1:0];
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // quiet the input, let every result drain, then write the register
  task automatic idle_write(input logic [PADDR_W-1:0] addr, input int unsigned data);
    in_valid_i <= 1'b0;
    while (pending_stats_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    apb_write(addr, data);
  endtask

  // offer one pixel at a falling edge and hold it until accepted
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input bit typed,
                            input pixel_stats_t typed_stats);
    pixel_stats_t p;
    in_valid_i <= 1'b1;
    pixel_value_i <= pix;
    do @(posedge clk_i); while (in_stall_o);
    p = welford_update(pix);
    pending_stats_q.push_back(typed ? typed_stats : p);
    @(negedge clk_i);
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  dir_row_t dir_rows[] = '{
    // first frame after reset: n is one, so mean is the pixel and variance zero
    '{ROW_CHECKED, '0, 0,   '{16'd0, 16'd1, 24'h000000, 30'd0}},
    '{ROW_CHECKED, '0, 255, '{16'd1, 16'd1, 24'hFF0000, 30'd0}},
    '{ROW_CHECKED, '0, 1,   '{16'd2, 16'd1, 24'h010000, 30'd0}},
    '{ROW_CHECKED, '0, 128, '{16'd3, 16'd1, 24'h800000, 30'd0}},
    '{ROW_CHECKED, '0, 85,  '{16'd4, 16'd1, 24'h550000, 30'd0}},
    // shrink the frame below the current position: restart at zero, frame two
    '{ROW_WRITE, ADDR_FRAME_PIXELS, 3, '{0, 0, 0, 0}},
    '{ROW_PIXEL, '0, 255, '{0, 0, 0, 0}},
    '{ROW_PIXEL, '0, 0,   '{0, 0, 0, 0}},
    '{ROW_PIXEL, '0, 0,   '{0, 0, 0, 0}},
    '{ROW_PIXEL, '0, 0,   '{0, 0, 0, 0}},
    '{ROW_PIXEL, '0, 255, '{0, 0, 0, 0}},
    // zero length acts as one pixel per frame
    '{ROW_WRITE, ADDR_FRAME_PIXELS, 0, '{0, 0, 0, 0}},
    '{ROW_PIXEL, '0, 255, '{0, 0, 0, 0}},
    '{ROW_PIXEL, '0, 0,   '{0, 0, 0, 0}},
    '{ROW_PIXEL, '0, 255, '{0, 0, 0, 0}},
    // write past the register map is ignored
    '{ROW_WRITE, ADDR_UNMAPPED, 5, '{0, 0, 0, 0}},
    '{ROW_PIXEL, '0, 128, '{0, 0, 0, 0}},
    // all-ones length clamps to the full store
    '{ROW_WRITE, ADDR_FRAME_PIXELS, 32'h1FFFF, '{0, 0, 0, 0}},
    '{ROW_PIXEL, '0, 255, '{0, 0, 0, 0}},
    '{ROW_PIXEL, '0, 1,   '{0, 0, 0, 0}},
    '{ROW_PIXEL, '0, 254, '{0, 0, 0, 0}}
  };

  int unsigned frame_settings[] = '{1, 2, 26, 27, 300, 0, 65536, 32'h1FFFF, 5};

  initial begin
    pixel_stats_t none;
    int left, burst;
    none = '{0, 0, 0, 0};
    for (int i = 0; i < NPIX; i++) begin
      mean_mem[i] = '0;
      devsum_mem[i] = '0;
    end
    raster_pos = 0;
    frame_cnt = 0;
    frame_len_reg = FP_RESET;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed table; the clearing pass just shows up as input stall
    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_WRITE:   idle_write(dir_rows[i].addr, dir_rows[i].value);
        ROW_CHECKED: send_pixel(PIX_W'(dir_rows[i].value), 1'b1, dir_rows[i].stats);
        default:     send_pixel(PIX_W'(dir_rows[i].value), 1'b0, none);
      endcase
    end

    // random pixels in bursts under a series of frame lengths
    foreach (frame_settings[s]) begin
      idle_write(ADDR_FRAME_PIXELS, frame_settings[s]);
      left = RAND_ITEMS;
      while (left > 0) begin
        burst = $urandom_range(1, 50);
        if (burst > left) burst = left;
        repeat (burst) send_pixel(rand_pixel(), 1'b0, none);
        left -= burst;
        if (s == 4 && left < RAND_ITEMS / 2 && left + burst >= RAND_ITEMS / 2)
          long_hold_req = 1'b1;  // sender keeps going while the receiver holds off
        if (s == 2 && left < RAND_ITEMS / 2 && left + burst >= RAND_ITEMS / 2) begin
          in_valid_i <= 1'b0;    // sender pauses until all results are back
          while (pending_stats_q.size() != 0) @(negedge clk_i);
        end else if ($urandom_range(0, 3) != 0) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 8)) @(negedge clk_i);
        end
      end
    end

    in_valid_i <= 1'b0;
    while (pending_stats_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (error_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
